// ===== design/ppci_pkg.sv =====
// ppci_pkg: shared widths, register index codes and the configuration struct
// for the positional pid block. No dependencies.
`default_nettype none

package ppci_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int GAIN_W       = 16;
  localparam int TIME_W       = 32;
  localparam int DRIVE_W      = 32;
  localparam int LIMIT_W      = 31;
  localparam int BAND_W       = 17;
  localparam int PERIOD_W     = 16;
  localparam int CFG_DATA_W   = 31;
  localparam int CFG_INDEX_W  = 3;

  // error and product widths
  localparam int ERR_W    = SAMPLE_WIDTH + 1;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int PROD_I_W = GAIN_W + ERR_W;
  localparam int PROD_D_W = GAIN_W + DIFF_W;
  localparam int ACC_W    = ((PROD_I_W > DRIVE_W) ? PROD_I_W : DRIVE_W) + 1;
  localparam int SUM_W    = ((PROD_D_W > ACC_W) ? PROD_D_W : ACC_W) + 2;
  localparam int CMP_W    = ((ERR_W > BAND_W) ? ERR_W : BAND_W) + 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_I         = 3'd1,
    CFG_GAIN_D         = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_ERROR_BAND     = 3'd4,
    CFG_SAMPLE_PERIOD  = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_p;
    logic [GAIN_W-1:0]   gain_i;
    logic [GAIN_W-1:0]   gain_d;
    logic [LIMIT_W-1:0]  integral_limit;
    logic [BAND_W-1:0]   error_band;
    logic [PERIOD_W-1:0] sample_period;
  } ppci_cfg_t;

endpackage

`default_nettype wire

// ===== design/ppci_in_if.sv =====
// ppci_in_if: valid/ready channel carrying one controller sample.
// Depends on ppci_pkg for the field widths.
`default_nettype none

interface ppci_in_if import ppci_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] setpoint;
  logic signed [SAMPLE_WIDTH-1:0] measured;
  logic [TIME_W-1:0]              time_ms;

  modport source (output valid, output setpoint, output measured, output time_ms,
                  input ready);
  modport sink   (input valid, input setpoint, input measured, input time_ms,
                  output ready);
endinterface

`default_nettype wire

// ===== design/ppci_out_if.sv =====
// ppci_out_if: valid/ready channel carrying one controller result.
// Depends on ppci_pkg for the field widths.
`default_nettype none

interface ppci_out_if import ppci_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      updated;

  modport source (output valid, output drive, output updated, input ready);
  modport sink   (input valid, input drive, input updated, output ready);
endinterface

`default_nettype wire

// ===== design/ppci_cfg_regs.sv =====
// ppci_cfg_regs: configuration register file written through the plain
// write port. Depends on ppci_pkg.
`default_nettype none

module ppci_cfg_regs import ppci_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output ppci_cfg_t                   cfg
);

  ppci_cfg_t cfg_r;
  ppci_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_P:         cfg_nxt.gain_p         = cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:         cfg_nxt.gain_i         = cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:         cfg_nxt.gain_d         = cfg_data[GAIN_W-1:0];
        CFG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = cfg_data[LIMIT_W-1:0];
        CFG_ERROR_BAND:     cfg_nxt.error_band     = cfg_data[BAND_W-1:0];
        CFG_SAMPLE_PERIOD:  cfg_nxt.sample_period  = cfg_data[PERIOD_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.integral_limit <= '1;
      cfg_r.error_band     <= '1;
      cfg_r.sample_period  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== design/ppci_core.sv =====
// ppci_core: one pid step per transfer with conditional integration when the
// sample period has elapsed (else the held drive is output), plus the controller
// state (integral, previous error, held drive, last update time). Depends on ppci_pkg.
`default_nettype none

module ppci_core import ppci_pkg::*; (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic signed [SAMPLE_WIDTH-1:0] setpoint,
  input  wire logic signed [SAMPLE_WIDTH-1:0] measured,
  input  wire logic [TIME_W-1:0]              time_ms,
  input  wire ppci_cfg_t                      cfg,
  output logic signed [DRIVE_W-1:0]           drive,
  output logic                                updated
);

  logic signed [DRIVE_W-1:0] integral_r;
  logic signed [ERR_W-1:0]   prev_err_r;
  logic signed [DRIVE_W-1:0] held_r;
  logic [TIME_W-1:0]         last_time_r;

  logic signed [GAIN_W-1:0]   kp, ki, kd;
  logic signed [ERR_W-1:0]    err;
  logic [TIME_W-1:0]          elapsed;
  logic                       do_upd;
  logic signed [CMP_W-1:0]    err_c, band_c;
  logic                       integrate;
  logic signed [PROD_I_W-1:0] prod_i, prod_p;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [ACC_W-1:0]    acc_sum, lim_c, acc_clamp;
  logic signed [DRIVE_W-1:0]  integral_nxt;
  logic signed [SUM_W-1:0]    d_sum;
  logic signed [DRIVE_W-1:0]  d_sat;

  assign kp = cfg.gain_p;
  assign ki = cfg.gain_i;
  assign kd = cfg.gain_d;

  assign err     = ERR_W'(setpoint) - ERR_W'(measured);
  assign elapsed = time_ms - last_time_r;
  assign do_upd  = elapsed >= TIME_W'(cfg.sample_period);

  // outside the band the integral may only move back toward zero
  assign err_c  = CMP_W'(err);
  assign band_c = CMP_W'($signed({1'b0, cfg.error_band}));
  always_comb begin
    if (err_c > band_c) begin
      integrate = integral_r < 0;
    end else if (err_c < -band_c) begin
      integrate = integral_r > 0;
    end else begin
      integrate = 1'b1;
    end
  end

  assign prod_i = ki * err;
  assign prod_p = kp * err;
  assign diff   = DIFF_W'(prev_err_r) - DIFF_W'(err);
  assign prod_d = kd * diff;

  assign acc_sum = integrate ? (ACC_W'(integral_r) + ACC_W'(prod_i)) : ACC_W'(integral_r);
  assign lim_c   = ACC_W'($signed({1'b0, cfg.integral_limit}));

  always_comb begin
    if (acc_sum > lim_c) begin
      acc_clamp = lim_c;
    end else if (acc_sum < -lim_c) begin
      acc_clamp = -lim_c;
    end else begin
      acc_clamp = acc_sum;
    end
    if (ki <= 0) begin
      integral_nxt = '0;
    end else begin
      integral_nxt = acc_clamp[DRIVE_W-1:0];
    end
  end

  assign d_sum = SUM_W'(prod_p) + SUM_W'(integral_nxt) - SUM_W'(prod_d);

  always_comb begin
    if (d_sum > SUM_W'($signed({1'b0, {(DRIVE_W-1){1'b1}}}))) begin
      d_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
    end else if (d_sum < SUM_W'($signed({1'b1, {(DRIVE_W-1){1'b0}}}))) begin
      d_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      d_sat = d_sum[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r  <= '0;
      prev_err_r  <= '0;
      held_r      <= '0;
      last_time_r <= '0;
    end else if (step && do_upd) begin
      integral_r  <= integral_nxt;
      prev_err_r  <= err;
      held_r      <= d_sat;
      last_time_r <= time_ms;
    end
  end

  assign drive   = do_upd ? d_sat : held_r;
  assign updated = do_upd;

endmodule

`default_nettype wire

// ===== design/pid_positional_conditional_integral.sv =====
// Positional pid controller with conditional integration. Every input transfer
// yields exactly one result transfer; an item passes the input register, then
// the result register. The rate is one item per cycle unless the output stalls,
// set by the pid update whose integral, previous error and held drive feed back
// into the next item. The user writes configuration through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block itself does not enforce this.
// Depends on ppci_pkg, ppci_in_if, ppci_out_if, ppci_cfg_regs and ppci_core.
`default_nettype none

module pid_positional_conditional_integral import ppci_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  ppci_in_if.sink                     in_ch,
  ppci_out_if.source                  out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  ppci_cfg_t cfg;

  logic                           s_valid_r, s_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] s_setpoint_r;
  logic signed [SAMPLE_WIDTH-1:0] s_measured_r;
  logic [TIME_W-1:0]              s_time_r;

  logic                      o_valid_r, o_valid_nxt;
  logic signed [DRIVE_W-1:0] o_drive_r;
  logic                      o_updated_r;

  logic                      adv;
  logic                      in_xfer;
  logic signed [DRIVE_W-1:0] core_drive;
  logic                      core_updated;

  ppci_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppci_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .setpoint (s_setpoint_r),
    .measured (s_measured_r),
    .time_ms  (s_time_r),
    .cfg      (cfg),
    .drive    (core_drive),
    .updated  (core_updated)
  );

  // item moves from the input register to the result register
  assign adv          = s_valid_r && (!o_valid_r || out_ch.ready);
  assign in_ch.ready  = !s_valid_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_xfer) begin
      s_valid_nxt = 1'b1;
    end else if (adv) begin
      s_valid_nxt = 1'b0;
    end
    o_valid_nxt = o_valid_r;
    if (adv) begin
      o_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s_setpoint_r <= in_ch.setpoint;
      s_measured_r <= in_ch.measured;
      s_time_r     <= in_ch.time_ms;
    end
    if (adv) begin
      o_drive_r   <= core_drive;
      o_updated_r <= core_updated;
    end
  end

  assign out_ch.valid   = o_valid_r;
  assign out_ch.drive   = o_drive_r;
  assign out_ch.updated = o_updated_r;

endmodule

`default_nettype wire
